// ===== hdl/msbr_pkg.sv =====
package msbr_pkg;

   localparam int HISTORY_WORDS = 8192;
   localparam int WORD_BITS     = 32;
   localparam int ADDR_W        = $clog2(HISTORY_WORDS);
   localparam int OFF_W         = $clog2(WORD_BITS);
   localparam int PTR_W         = ADDR_W + OFF_W;
   localparam int CNT_W         = PTR_W + 1;
   localparam int REQ_W         = 12;
   localparam int TOTAL_W       = 40;
   localparam int FIELD_BITS    = 32;

   localparam logic [CNT_W-1:0] RING_BITS = CNT_W'(HISTORY_WORDS * WORD_BITS);

   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_GET    = 3'd1,
      MODE_PEEK   = 3'd2,
      MODE_SKIP   = 3'd3,
      MODE_UNGET  = 3'd4,
      MODE_ZEROS  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_TOO_BIG = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH2,
      ST_EXTRACT,
      ST_ZSCAN
   } state_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [31:0]      word_in;
      logic [REQ_W-1:0] bit_count_req;
   } req_type;

   typedef struct packed {
      logic [31:0]        field_value;
      logic               all_zero;
      logic [1:0]         status;
      logic [TOTAL_W-1:0] bits_consumed;
   } rsp_type;

endpackage

// ===== hdl/msb_first_bit_reader.sv =====
// Append, skip, unget and unused modes: result in the next cycle, one request per cycle.
// Get, peek: busy over two ring reads (fetch and extract states); refused ones answer like append.
// Check zeros: the scan reads one ring word at a time, over the ring words spanned by the buffered
// bits examined (at most 129); a nonzero word ends the scan early; with no bits, there is no scan.
// Synchronous reset clears pointers, counters and control; the ring itself is not cleared.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
module msb_first_bit_reader (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  msbr_pkg::req_type req_data,
   output logic             rsp_valid,
   output msbr_pkg::rsp_type rsp_data
);

   localparam int AW = msbr_pkg::ADDR_W;
   localparam int OW = msbr_pkg::OFF_W;
   localparam int PW = msbr_pkg::PTR_W;
   localparam int CW = msbr_pkg::CNT_W;
   localparam int RW = msbr_pkg::REQ_W;
   localparam int TW = msbr_pkg::TOTAL_W;
   localparam int WB = msbr_pkg::WORD_BITS;

   logic [WB-1:0] ring [msbr_pkg::HISTORY_WORDS];
   logic [WB-1:0] rdata_ff;

   msbr_pkg::state_type state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [CW-1:0] ahead_ff, ahead_in;
   logic [CW-1:0] behind_ff, behind_in;
   logic [TW-1:0] total_ff, total_in;

   logic [AW-1:0] addr_ff, addr_in;   // word base for fetch, next word for scan
   logic [OW-1:0] off_ff, off_in;
   logic [5:0]    n_ff, n_in;         // get/peek request length
   logic [5:0]    k_ff, k_in;         // get/peek bits actually buffered
   logic [RW-1:0] zrem_ff, zrem_in;
   logic [1:0]    zst_ff, zst_in;
   logic [WB-1:0] w0_ff, w0_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   msbr_pkg::rsp_type    rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] rd_addr;

   logic          accept;
   logic [RW-1:0] n;
   logic [CW-1:0] n_ext;
   logic [CW-1:0] fill;
   logic [RW-1:0] avail;

   logic [2*WB-1:0] cat;
   logic [WB-1:0]   top;
   logic [WB-1:0]   field;
   logic [6:0]      take;
   logic [6:0]      room;
   logic [WB-1:0]   zmask;
   logic            znz;

   assign accept = start && !busy;
   assign busy   = (state_ff != msbr_pkg::ST_IDLE);
   assign n      = req_data.bit_count_req;
   assign n_ext  = CW'(n);
   assign fill   = ahead_ff + behind_ff + CW'(WB);
   assign avail  = (n_ext > ahead_ff) ? ahead_ff[RW-1:0] : n;

   // field extraction from the two fetched words
   assign cat   = {w0_ff, rdata_ff} << off_ff;
   assign top   = cat[2*WB-1:WB];
   assign field = (k_ff == 6'd0) ? '0 : ((top >> (6'd32 - k_ff)) << (n_ff - k_ff));

   // zero scan over one word
   assign room  = 7'd32 - 7'(off_ff);
   assign take  = (13'(zrem_ff) < 13'(room)) ? 7'(zrem_ff) : room;
   assign zmask = ~({WB{1'b1}} >> take);
   assign znz   = |((rdata_ff << off_ff) & zmask);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      ahead_in     = ahead_ff;
      behind_in    = behind_ff;
      total_in     = total_ff;
      addr_in      = addr_ff;
      off_in       = off_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      zrem_in      = zrem_ff;
      zst_in       = zst_ff;
      w0_in        = w0_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      rd_addr      = rp_ff[PW-1:OW];

      case (state_ff)
         msbr_pkg::ST_IDLE: begin
            rd_addr = rp_ff[PW-1:OW];
            if (accept) begin
               rsp_in.field_value = '0;
               rsp_in.all_zero    = 1'b0;
               rsp_in.status      = msbr_pkg::STATUS_OK;
               rsp_in.bits_consumed = total_ff;
               rsp_valid_in       = 1'b1;
               addr_in            = rp_ff[PW-1:OW];
               off_in             = rp_ff[OW-1:0];
               case (req_data.mode)
                  msbr_pkg::MODE_APPEND: begin
                     if (ahead_ff > msbr_pkg::RING_BITS - CW'(WB)) begin
                        rsp_in.status = msbr_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wp_in    = wp_ff + AW'(1);
                        ahead_in = ahead_ff + CW'(WB);
                        if (fill > msbr_pkg::RING_BITS) begin
                           behind_in = msbr_pkg::RING_BITS - ahead_ff - CW'(WB);
                        end
                     end
                  end
                  msbr_pkg::MODE_GET, msbr_pkg::MODE_PEEK: begin
                     if (n > RW'(msbr_pkg::FIELD_BITS)) begin
                        rsp_in.status = msbr_pkg::STATUS_TOO_BIG;
                     end else if (req_data.mode == msbr_pkg::MODE_GET && n_ext > ahead_ff) begin
                        rsp_in.status = msbr_pkg::STATUS_SHORT;
                     end else begin
                        rsp_valid_in = 1'b0;
                        n_in         = n[5:0];
                        k_in         = avail[5:0];
                        state_in     = msbr_pkg::ST_FETCH2;
                        if (req_data.mode == msbr_pkg::MODE_GET) begin
                           rp_in     = rp_ff + PW'(n);
                           ahead_in  = ahead_ff - n_ext;
                           behind_in = behind_ff + n_ext;
                           total_in  = total_ff + TW'(n);
                        end
                     end
                  end
                  msbr_pkg::MODE_SKIP: begin
                     // a 12-bit count never exceeds the request limit
                     if (n_ext > ahead_ff) begin
                        rsp_in.status = msbr_pkg::STATUS_SHORT;
                     end else begin
                        rp_in     = rp_ff + PW'(n);
                        ahead_in  = ahead_ff - n_ext;
                        behind_in = behind_ff + n_ext;
                        total_in  = total_ff + TW'(n);
                        rsp_in.bits_consumed = total_ff + TW'(n);
                     end
                  end
                  msbr_pkg::MODE_UNGET: begin
                     if (n_ext > behind_ff) begin
                        rsp_in.status = msbr_pkg::STATUS_FULL;
                     end else begin
                        rp_in     = rp_ff - PW'(n);
                        ahead_in  = ahead_ff + n_ext;
                        behind_in = behind_ff - n_ext;
                        total_in  = total_ff - TW'(n);
                        rsp_in.bits_consumed = total_ff - TW'(n);
                     end
                  end
                  msbr_pkg::MODE_ZEROS: begin
                     zst_in = (n_ext > ahead_ff) ? msbr_pkg::STATUS_SHORT : msbr_pkg::STATUS_OK;
                     if (avail == '0) begin
                        rsp_in.all_zero = 1'b1;
                        rsp_in.status   = (n_ext > ahead_ff) ? msbr_pkg::STATUS_SHORT
                                                             : msbr_pkg::STATUS_OK;
                     end else begin
                        rsp_valid_in = 1'b0;
                        zrem_in      = avail;
                        addr_in      = rp_ff[PW-1:OW] + AW'(1);
                        state_in     = msbr_pkg::ST_ZSCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         msbr_pkg::ST_FETCH2: begin
            w0_in    = rdata_ff;
            rd_addr  = addr_ff + AW'(1);
            state_in = msbr_pkg::ST_EXTRACT;
         end
         msbr_pkg::ST_EXTRACT: begin
            rsp_in.field_value   = field;
            rsp_in.all_zero      = 1'b0;
            rsp_in.status        = msbr_pkg::STATUS_OK;
            rsp_in.bits_consumed = total_ff;
            rsp_valid_in         = 1'b1;
            state_in             = msbr_pkg::ST_IDLE;
         end
         msbr_pkg::ST_ZSCAN: begin
            // data for the current word is in rdata_ff; the next word is requested here
            rd_addr = addr_ff;
            addr_in = addr_ff + AW'(1);
            off_in  = '0;
            zrem_in = zrem_ff - RW'(take);
            if (znz || (13'(zrem_ff) == 13'(take))) begin
               rsp_in.field_value   = '0;
               rsp_in.all_zero      = !znz;
               rsp_in.status        = zst_ff;
               rsp_in.bits_consumed = total_ff;
               rsp_valid_in         = 1'b1;
               state_in             = msbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msbr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wp_ff] <= req_data.word_in;
      end
      rdata_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msbr_pkg::ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         ahead_ff     <= '0;
         behind_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         ahead_ff     <= ahead_in;
         behind_ff    <= behind_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      off_ff  <= off_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      zrem_ff <= zrem_in;
      zst_ff  <= zst_in;
      w0_ff   <= w0_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      (20'(ahead_ff) + 20'(behind_ff)) <= 20'(msbr_pkg::RING_BITS))
      else $error("buffered plus history bits exceed ring size");

   a_fetch_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == msbr_pkg::ST_FETCH2 |=> state_ff == msbr_pkg::ST_EXTRACT && rsp_valid == 1'b0)
      else $error("fetch did not proceed to extract");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.mode == msbr_pkg::MODE_APPEND || req_data.mode == msbr_pkg::MODE_SKIP
                 || req_data.mode == msbr_pkg::MODE_UNGET) |=> rsp_valid && !busy)
      else $error("single-cycle request gave no result");

   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == msbr_pkg::ST_EXTRACT |=> rsp_valid)
      else $error("extract gave no result");
`endif

endmodule

// ===== test/tb_msb_first_bit_reader.sv =====
`timescale 1ns / 100ps

import msbr_pkg::*;

localparam int MAX_REQ_BITS = 4095;
localparam logic [2:0] MODE_SPARE_LO = 3'd6;
localparam logic [2:0] MODE_SPARE_HI = 3'd7;

class bit_reader_scoreboard;
   logic [WORD_BITS-1:0] ring [HISTORY_WORDS];
   bit [ADDR_W-1:0]  wr_word;
   bit [PTR_W-1:0]   rd_bit;
   bit [CNT_W-1:0]   ahead;
   bit [CNT_W-1:0]   behind;
   bit [TOTAL_W-1:0] consumed;
   rsp_type          pending_rsp[$];
   int               mismatches;
   int               responses_seen;
   int               mode_seen[8];
   int               status_seen[4];

   function bit stream_bit(int unsigned offset);
      bit [PTR_W-1:0] pos;
      int             idx;
      pos = rd_bit + PTR_W'(offset);
      idx = WORD_BITS - 1 - int'(pos[OFF_W-1:0]);
      return ring[pos[PTR_W-1:OFF_W]][idx];
   endfunction

   function rsp_type stream_result(req_type r);
      rsp_type     e;
      int unsigned n;
      int unsigned limit;
      int unsigned avail;
      e = '0;
      e.status = STATUS_OK;
      n = 32'(r.bit_count_req);
      case (r.mode)
         MODE_APPEND: begin
            if (int'(ahead) + WORD_BITS > int'(RING_BITS)) begin
               e.status = STATUS_FULL;
            end else begin
               ring[wr_word] = r.word_in;
               wr_word++;
               // oldest history is overwritten once the ring wraps
               if (int'(ahead) + int'(behind) + WORD_BITS > int'(RING_BITS))
                  behind = CNT_W'(int'(RING_BITS) - int'(ahead) - WORD_BITS);
               ahead = ahead + CNT_W'(WORD_BITS);
            end
         end
         MODE_GET, MODE_SKIP: begin
            limit = (r.mode == MODE_GET) ? FIELD_BITS : MAX_REQ_BITS;
            if (n > limit) begin
               e.status = STATUS_TOO_BIG;
            end else if (n > 32'(ahead)) begin
               e.status = STATUS_SHORT;
            end else begin
               if (r.mode == MODE_GET)
                  for (int i = 0; i < n; i++)
                     e.field_value = {e.field_value[30:0], stream_bit(i)};
               rd_bit   = rd_bit + PTR_W'(n);
               ahead    = ahead - CNT_W'(n);
               behind   = behind + CNT_W'(n);
               consumed = consumed + TOTAL_W'(n);
            end
         end
         MODE_PEEK: begin
            if (n > FIELD_BITS) begin
               e.status = STATUS_TOO_BIG;
            end else begin
               // bits past the buffered data read as zero
               for (int i = 0; i < n; i++)
                  e.field_value = {e.field_value[30:0], (i < ahead) ? stream_bit(i) : 1'b0};
            end
         end
         MODE_UNGET: begin
            if (n > 32'(behind)) begin
               e.status = STATUS_FULL;
            end else begin
               rd_bit   = rd_bit - PTR_W'(n);
               ahead    = ahead + CNT_W'(n);
               behind   = behind - CNT_W'(n);
               consumed = consumed - TOTAL_W'(n);
            end
         end
         MODE_ZEROS: begin
            if (n > MAX_REQ_BITS) begin
               e.status = STATUS_TOO_BIG;
            end else begin
               avail = (n < 32'(ahead)) ? n : 32'(ahead);
               e.all_zero = 1'b1;
               for (int i = 0; i < avail; i++)
                  if (stream_bit(i)) e.all_zero = 1'b0;
               if (n > 32'(ahead)) e.status = STATUS_SHORT;
            end
         end
         default: ;
      endcase
      e.bits_consumed = consumed;
      return e;
   endfunction

   function void take_request(req_type r);
      mode_seen[r.mode]++;
      pending_rsp.push_back(stream_result(r));
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function void match_response(rsp_type a);
      rsp_type e;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         $display("%0t: response with none pending, actual %h", $time, a);
         return;
      end
      e = pending_rsp.pop_front();
      responses_seen++;
      status_seen[a.status]++;
      compare_field("field_value", 64'(e.field_value), 64'(a.field_value));
      compare_field("all_zero", 64'(e.all_zero), 64'(a.all_zero));
      compare_field("status", 64'(e.status), 64'(a.status));
      compare_field("bits_consumed", 64'(e.bits_consumed), 64'(a.bits_consumed));
   endfunction
endclass

module tb_msb_first_bit_reader;

   localparam int DRAIN_CYCLES = 140;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   bit_reader_scoreboard sb;
   bit idle_on = 1'b1;
   int requests_sent;

   msb_first_bit_reader uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.match_response(rsp_data);
   end

   task automatic issue(input logic [2:0] mode, input logic [31:0] word,
                        input logic [REQ_W-1:0] count);
      req_type r;
      r.mode          = mode;
      r.word_in       = word;
      r.bit_count_req = count;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.take_request(r);
      requests_sent++;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic random_request();
      int               pick;
      logic [2:0]       mode;
      logic [31:0]      word;
      logic [REQ_W-1:0] count;
      word  = $urandom;
      count = REQ_W'($urandom_range(0, 32));
      pick  = $urandom_range(0, 99);
      // keep the buffer fed so reads mostly succeed
      if (sb.ahead < 96 && pick < 50) pick = 0;
      if (pick < 22) begin
         mode = MODE_APPEND;
         case ($urandom_range(0, 9))
            0: word = '0;
            1: word = 32'h1 << $urandom_range(0, 31);
            default: ;
         endcase
      end else if (pick < 40) begin
         mode = MODE_GET;
      end else if (pick < 52) begin
         mode = MODE_PEEK;
      end else if (pick < 64) begin
         mode  = MODE_SKIP;
         count = REQ_W'($urandom_range(0, 96));
      end else if (pick < 76) begin
         mode  = MODE_UNGET;
         count = REQ_W'($urandom_range(0, 96));
      end else if (pick < 96) begin
         mode  = MODE_ZEROS;
         count = REQ_W'($urandom_range(0, 200));
      end else begin
         mode = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
      end
      if ($urandom_range(0, 9) == 0) count = REQ_W'($urandom);
      issue(mode, word, count);
   endtask

   initial begin
      int guard;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty buffer, zero counts, too-large counts, padding, history limits
      issue(MODE_GET,    32'h0, 12'd0);
      issue(MODE_GET,    32'h0, 12'd1);
      issue(MODE_PEEK,   32'h0, 12'd8);
      issue(MODE_ZEROS,  32'h0, 12'd0);
      issue(MODE_ZEROS,  32'h0, 12'd5);
      issue(MODE_UNGET,  32'h0, 12'd1);
      issue(MODE_APPEND, 32'hFFFF_FFFF, 12'hFFF);
      issue(MODE_APPEND, 32'h0000_0000, 12'd0);
      issue(MODE_APPEND, 32'h8000_0001, 12'd0);
      issue(MODE_GET,    32'h0, 12'd33);
      issue(MODE_GET,    32'h0, 12'd32);
      issue(MODE_PEEK,   32'h0, 12'd33);
      issue(MODE_PEEK,   32'h0, 12'd32);
      issue(MODE_ZEROS,  32'h0, 12'd32);
      issue(MODE_SKIP,   32'h0, 12'd4095);
      issue(MODE_SKIP,   32'h0, 12'd32);
      issue(MODE_GET,    32'h0, 12'd1);
      issue(MODE_UNGET,  32'h0, 12'd66);
      issue(MODE_UNGET,  32'h0, 12'd65);
      issue(MODE_ZEROS,  32'h0, 12'd4095);
      issue(MODE_SKIP,   32'h0, 12'd80);
      issue(MODE_PEEK,   32'h0, 12'd32);
      issue(MODE_SPARE_LO, 32'hFFFF_FFFF, 12'hFFF);
      issue(MODE_SPARE_HI, 32'h0, 12'd0);
      issue(MODE_GET,    32'h0, 12'd16);

      for (int i = 0; i < 1675; i++) begin
         if (i % 100 == 0) idle_on = (i < 1400) && ($urandom_range(0, 3) != 0);
         random_request();
      end
      start <= 1'b0;

      guard = 0;
      while (sb.pending_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d append, %0d get, %0d peek, %0d skip, %0d unget, %0d zeros",
               requests_sent, sb.mode_seen[MODE_APPEND], sb.mode_seen[MODE_GET],
               sb.mode_seen[MODE_PEEK], sb.mode_seen[MODE_SKIP], sb.mode_seen[MODE_UNGET],
               sb.mode_seen[MODE_ZEROS]);
      $display("Checked %0d responses; status ok %0d, short %0d, too big %0d, full %0d",
               sb.responses_seen, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_SHORT],
               sb.status_seen[STATUS_TOO_BIG], sb.status_seen[STATUS_FULL]);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Timeout waiting for the reader");
      $display("Some tests failed");
      $finish;
   end

endmodule
